FILE: hw/rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_front, utf8d_queue, utf8d_back and utf8_stream_decoder_core.
package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

    localparam logic [2:0] LEN_BAD  = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THR  = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // One queue entry: a run of replacements for flushed bytes, then an optional
    // final result. Never empty when pushed.
    typedef struct packed {
        logic [1:0]      flush_n;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_bad;
        logic [2:0]      tail_used;
    } t_job;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_BAD;
        if (b[7] == 1'b0)               len = LEN_ONE;
        else if (b[7:5] == 3'b110)      len = LEN_TWO;
        else if (b[7:4] == 4'b1110)     len = LEN_THR;
        else if (b[7:3] == 5'b11110)    len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic [4:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
        logic [4:0] bits;
        case (len)
            LEN_TWO:  bits = b[4:0];
            LEN_THR:  bits = {1'b0, b[3:0]};
            LEN_FOUR: bits = {2'b00, b[2:0]};
            default:  bits = 5'd0;
        endcase
        return bits;
    endfunction

    function automatic logic [CP_W-1:0] min_for_len(input logic [2:0] len);
        logic [CP_W-1:0] m;
        case (len)
            LEN_TWO:  m = 21'h000080;
            LEN_THR:  m = 21'h000800;
            LEN_FOUR: m = 21'h010000;
            default:  m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/utf8d_front.sv
// Front end: accepts bytes, tracks the open sequence and classifies each beat
// into a job for the queue. Depends on utf8d_pkg.
module utf8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_text,
    output logic              o_push,
    output utf8d_pkg::t_job   o_job
);

    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_exp,  n_exp;
    // leader bits plus at most two continuation groups before completion
    logic [14:0] r_part, n_part;

    logic                        is_cont;
    logic [2:0]                  cnt1;
    logic [2:0]                  len;
    logic [utf8d_pkg::CP_W-1:0]  acc;
    logic                        acc_bad;
    logic [14:0]                 lead_val;
    utf8d_pkg::t_job             job;

    assign is_cont  = (i_data_byte[7:6] == 2'b10);
    assign cnt1     = {1'b0, r_pend} + 3'd1;
    assign len      = utf8d_pkg::lead_len(i_data_byte);
    assign acc      = {r_part, i_data_byte[5:0]};
    assign lead_val = {10'd0, utf8d_pkg::lead_bits(i_data_byte, len)};
    assign acc_bad  = (acc < utf8d_pkg::min_for_len(r_exp))
                   || (acc inside {[utf8d_pkg::SURR_LO:utf8d_pkg::SURR_HI]})
                   || (acc > utf8d_pkg::MAX_SCALAR);

    always_comb begin
        n_pend = r_pend;
        n_exp  = r_exp;
        n_part = r_part;
        job    = '0;
        if (i_accept) begin
            if (r_pend != 2'd0 && is_cont) begin
                if (cnt1 >= r_exp) begin
                    job.has_tail  = 1'b1;
                    job.tail_cp   = acc_bad ? utf8d_pkg::REPLACEMENT : acc;
                    job.tail_bad  = acc_bad;
                    job.tail_used = r_exp;
                    n_pend = 2'd0;
                    n_exp  = 3'd0;
                    n_part = '0;
                end else if (i_end_of_text) begin
                    job.flush_n = cnt1[1:0];
                    n_pend = 2'd0;
                    n_exp  = 3'd0;
                    n_part = '0;
                end else begin
                    n_pend = cnt1[1:0];
                    n_part = acc[14:0];
                end
            end else begin
                // no open sequence, or open sequence broken: one replacement per pending byte
                job.flush_n = r_pend;
                n_pend = 2'd0;
                n_exp  = 3'd0;
                n_part = '0;
                if (len == utf8d_pkg::LEN_BAD || (len != utf8d_pkg::LEN_ONE && i_end_of_text)) begin
                    job.has_tail  = 1'b1;
                    job.tail_cp   = utf8d_pkg::REPLACEMENT;
                    job.tail_bad  = 1'b1;
                    job.tail_used = 3'd1;
                end else if (len == utf8d_pkg::LEN_ONE) begin
                    job.has_tail  = 1'b1;
                    job.tail_cp   = {13'd0, i_data_byte};
                    job.tail_bad  = 1'b0;
                    job.tail_used = 3'd1;
                end else begin
                    n_pend = 2'd1;
                    n_exp  = len;
                    n_part = lead_val;
                end
            end
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.flush_n != 2'd0 || job.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_exp  <= 3'd0;
            r_part <= '0;
        end else begin
            r_pend <= n_pend;
            r_exp  <= n_exp;
            r_part <= n_part;
        end
    end

`ifndef SYNTHESIS
    a_pend_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> ({1'b0, r_pend} < r_exp))
        else $error("open sequence count reached its length");

    a_closed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_exp == 3'd0))
        else $error("length held with no sequence open");

    a_eot_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (r_pend == 2'd0))
        else $error("sequence left open after end of text");
`endif

endmodule

FILE: hw/rtl/utf8d_queue.sv
// Small job queue between front and back ends; show-ahead head entry.
// Depends on utf8d_pkg.
module utf8d_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8d_pkg::t_job  i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output utf8d_pkg::t_job  o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    utf8d_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wr] <= i_job;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_valid |-> (o_head.flush_n != 2'd0 || o_head.has_tail))
        else $error("queue entry carries no result");
`endif

endmodule

FILE: hw/rtl/utf8d_back.sv
// Back end: expands queued jobs into result beats, one per cycle while the output
// is not stalled, into the output register. Depends on utf8d_pkg.
module utf8d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  utf8d_pkg::t_job             i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [utf8d_pkg::CP_W-1:0]  o_scalar_value,
    output logic                        o_bad_sequence,
    output logic [2:0]                  o_bytes_used,
    output logic                        o_last_of_run
);

    logic [1:0]                 r_sub;
    logic                       r_valid;
    logic [utf8d_pkg::CP_W-1:0] r_cp;
    logic                       r_bad;
    logic [2:0]                 r_used;
    logic                       r_last;

    logic                       load;
    logic                       in_flush;
    logic                       beat_last;
    logic [utf8d_pkg::CP_W-1:0] beat_cp;
    logic                       beat_bad;
    logic [2:0]                 beat_used;

    assign load     = i_head_valid && (!r_valid || i_out_ready);
    assign in_flush = (r_sub < i_head.flush_n);

    always_comb begin
        if (in_flush) begin
            beat_cp   = utf8d_pkg::REPLACEMENT;
            beat_bad  = 1'b1;
            beat_used = 3'd1;
            beat_last = ({1'b0, r_sub} + 3'd1 == {1'b0, i_head.flush_n}) && !i_head.has_tail;
        end else begin
            beat_cp   = i_head.tail_cp;
            beat_bad  = i_head.tail_bad;
            beat_used = i_head.tail_used;
            beat_last = 1'b1;
        end
    end

    assign o_pop = load && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= beat_last ? 2'd0 : r_sub + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_cp   <= beat_cp;
            r_bad  <= beat_bad;
            r_used <= beat_used;
            r_last <= beat_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_scalar_value = r_cp;
    assign o_bad_sequence = r_bad;
    assign o_bytes_used   = r_used;
    assign o_last_of_run  = r_last;

`ifndef SYNTHESIS
    a_sub_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_sub <= i_head.flush_n))
        else $error("result index past end of job");

    a_sub_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_sub == 2'd0))
        else $error("result index left set with queue empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> (r_valid && $stable({r_cp, r_bad, r_used, r_last})))
        else $error("result beat changed while stalled");
`endif

endmodule

FILE: hw/rtl/utf8_stream_decoder_core.sv
// Channel  | beat                              | direction
// ---------+-----------------------------------+----------
// in       | data_byte, end_of_text            | to block
// out      | scalar_value, bad_sequence,       | from block
//          | bytes_used, last_of_run           |
//
// One byte accepted per cycle; result beats leave through the output register,
// and a byte yielding k results (0..4) has them emitted by the back end one after another.
// Input stalls only when the job queue (QUEUE_DEPTH entries) is full.
// Synchronous active-low reset clears the open sequence, queue and output valid.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
module utf8_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_text,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [utf8d_pkg::CP_W-1:0]  o_scalar_value,
    output logic                        o_bad_sequence,
    output logic [2:0]                  o_bytes_used,
    output logic                        o_last_of_run
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    utf8d_pkg::t_job job;
    utf8d_pkg::t_job head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    utf8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_job         (job)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    utf8d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scalar_value (o_scalar_value),
        .o_bad_sequence (o_bad_sequence),
        .o_bytes_used   (o_bytes_used),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
